[src/srp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// srp_pkg
// shared types, constants and the arctangent table for the ray projector
// ----------------------------------------------------------------------------
package srp_pkg;

   localparam int MaxRays    = 4096;
   localparam bit InfIsValid = 1'b0;
   localparam int CountCapInt = (MaxRays < 8191) ? MaxRays : 8191;
   localparam logic [12:0] CountCap = 13'(CountCapInt);

   localparam int CordicIters = 16;
   localparam logic signed [33:0] CordicGain = 34'sd652032874;

   localparam logic [1:0] KIND_FINITE = 2'd0;
   localparam logic [1:0] KIND_POSINF = 2'd1;

   localparam logic [2:0] REG_START_ANGLE = 3'd0;
   localparam logic [2:0] REG_ANGLE_STEP  = 3'd1;
   localparam logic [2:0] REG_RANGE_MIN   = 3'd2;
   localparam logic [2:0] REG_RANGE_MAX   = 3'd3;
   localparam logic [2:0] REG_OBST_LIMIT  = 3'd4;
   localparam logic [2:0] REG_STRIDE      = 3'd5;
   localparam logic [2:0] REG_SENSOR_X    = 3'd6;
   localparam logic [2:0] REG_SENSOR_Y    = 3'd7;

   // classified ray handed from front to back
   typedef struct packed {
      logic        point;
      logic        counted;
      logic [12:0] count;
      logic        last;
      logic [15:0] range;
      logic [15:0] angle;
   } ray_type;

   function automatic logic signed [15:0] atan_entry(input logic [3:0] i);
      logic signed [15:0] r;
      begin
         case (i)
            4'd0: r = 16'sd8192;   4'd1: r = 16'sd4836;
            4'd2: r = 16'sd2555;   4'd3: r = 16'sd1297;
            4'd4: r = 16'sd651;    4'd5: r = 16'sd326;
            4'd6: r = 16'sd163;    4'd7: r = 16'sd81;
            4'd8: r = 16'sd41;     4'd9: r = 16'sd20;
            4'd10: r = 16'sd10;    4'd11: r = 16'sd5;
            4'd12: r = 16'sd3;     4'd13: r = 16'sd1;
            4'd14: r = 16'sd1;     default: r = 16'sd0;
         endcase
         return r;
      end
   endfunction

endpackage
`default_nettype wire

[src/srp_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// srp_front
// keeps angle, stride phase and valid count; classifies each ray
// ----------------------------------------------------------------------------
module srp_front import srp_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        take,
   input  wire logic [15:0] range_mm,
   input  wire logic [1:0]  range_kind,
   input  wire logic        first_ray,
   input  wire logic        last_ray,
   input  wire logic [15:0] start_angle,
   input  wire logic [15:0] angle_step,
   input  wire logic [15:0] min_range,
   input  wire logic [15:0] max_range,
   input  wire logic [15:0] obstacle_limit,
   input  wire logic [4:0]  stride,
   output ray_type          ray
);
   logic [15:0] angle_ff, angle_in, ang;
   logic [3:0]  phase_ff, phase_in, phase;
   logic [12:0] total_ff, total_in, total;
   logic [4:0]  eff_stride, phase_inc;
   logic        hit, clr, counted;

   always_comb begin
      eff_stride = (stride == 5'd0) ? 5'd1 : ((stride > 5'd16) ? 5'd16 : stride);
      ang   = first_ray ? start_angle : angle_ff;
      phase = first_ray ? 4'd0 : phase_ff;
      total = first_ray ? 13'd0 : total_ff;
      hit = (range_kind == KIND_FINITE) && (range_mm >= min_range) &&
            (range_mm <= max_range);
      clr = InfIsValid && ((range_kind == KIND_POSINF) ||
            ((range_kind == KIND_FINITE) && (range_mm > max_range)));
      counted = (phase == 4'd0) && (hit || clr);
      total_in = (counted && total < CountCap) ? total + 13'd1 : total;
      phase_inc = {1'b0, phase} + 5'd1;
      phase_in = (phase_inc >= eff_stride) ? 4'd0 : phase_inc[3:0];
      angle_in = ang + angle_step;
      ray.point   = (phase == 4'd0) && hit && (range_mm <= obstacle_limit);
      ray.counted = counted;
      ray.count   = total_in;
      ray.last    = last_ray;
      ray.range   = range_mm;
      ray.angle   = ang;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_ff <= '0;
         phase_ff <= '0;
         total_ff <= '0;
      end else if (take) begin
         angle_ff <= angle_in;
         phase_ff <= phase_in;
         total_ff <= total_in;
      end
   end
endmodule
`default_nettype wire

[src/srp_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// srp_fifo
// four-entry queue of classified rays between front and back
// ----------------------------------------------------------------------------
module srp_fifo import srp_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  ray_type   push_data,
   output logic      full,
   input  wire logic pop,
   output logic      not_empty,
   output ray_type   pop_data
);
   ray_type     mem [4];
   logic [1:0]  wr_ff, rd_ff;
   logic [2:0]  cnt_ff;

   assign full      = cnt_ff == 3'd4;
   assign not_empty = cnt_ff != 3'd0;
   assign pop_data  = mem[rd_ff];

   always_ff @(posedge clock) begin
      if (push) mem[wr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 2'd1;
         if (pop)  rd_ff <= rd_ff + 2'd1;
         cnt_ff <= cnt_ff + {2'd0, push} - {2'd0, pop};
      end
   end
endmodule
`default_nettype wire

[src/srp_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// srp_back
// pipelined cordic, range multiply and sensor offset; output register
// ----------------------------------------------------------------------------
module srp_back import srp_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_valid,
   input  ray_type          in_ray,
   output logic             in_ready,
   input  wire logic [22:0] base_x,
   input  wire logic [22:0] base_y,
   output logic             out_valid,
   input  wire logic        out_ready,
   output logic [63:0]      out_data
);
   localparam int Stages = CordicIters + 3;

   // stage 0..16 cordic, then q15 + quadrant, multiply, add
   logic               v_ff [Stages+1];
   ray_type            r_ff [Stages+1];
   logic signed [33:0] x_ff [CordicIters+1];
   logic signed [33:0] y_ff [CordicIters+1];
   logic signed [16:0] z_ff [CordicIters+1];
   logic signed [16:0] c_ff, s_ff, c_in, s_in, cr, sr;
   logic signed [33:0] mx_ff, my_ff;
   logic signed [34:0] tx_ff, ty_ff, tx_in, ty_in;
   logic [63:0]        out_ff;
   logic               ov_ff;
   logic               adv;

   function automatic logic signed [16:0] q15(input logic signed [33:0] v);
      logic signed [33:0] r;
      begin
         r = (v + 34'sd16384) >>> 15;
         if (r > 34'sd32767) return 17'sd32767;
         if (r < -34'sd32768) return -17'sd32768;
         return 17'(r);
      end
   endfunction

   function automatic logic signed [23:0] sat24(input logic signed [34:0] v);
      begin
         if (v > 35'sd8388607) return 24'sh7FFFFF;
         if (v < -35'sd8388608) return 24'sh800000;
         return 24'(v);
      end
   endfunction

   // whole pipe stalls together when the output register is held
   assign adv       = !ov_ff || out_ready;
   assign in_ready  = adv;
   assign out_valid = ov_ff;
   assign out_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= Stages; i++) v_ff[i] <= 1'b0;
         ov_ff <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= in_valid;
         for (int i = 1; i <= Stages; i++) v_ff[i] <= v_ff[i-1];
         ov_ff <= v_ff[Stages];
      end
   end

   always_comb begin
      cr = q15(x_ff[CordicIters]);
      sr = q15(y_ff[CordicIters]);
      case (r_ff[CordicIters].angle[15:14])
         2'd0: begin c_in = cr;  s_in = sr;  end
         2'd1: begin c_in = -sr; s_in = cr;  end
         2'd2: begin c_in = -cr; s_in = -sr; end
         default: begin c_in = sr; s_in = -cr; end
      endcase
      if (c_in > 17'sd32767) c_in = 17'sd32767;
      if (s_in > 17'sd32767) s_in = 17'sd32767;
      tx_in = $signed({{12{base_x[22]}}, base_x}) + 35'((mx_ff + 34'sd16384) >>> 15);
      ty_in = $signed({{12{base_y[22]}}, base_y}) + 35'((my_ff + 34'sd16384) >>> 15);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r_ff[0] <= in_ray;
         x_ff[0] <= CordicGain;
         y_ff[0] <= '0;
         z_ff[0] <= {3'd0, in_ray.angle[13:0]};
         for (int i = 0; i < CordicIters; i++) begin
            r_ff[i+1] <= r_ff[i];
            if (!z_ff[i][16]) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - 17'(atan_entry(4'(i)));
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + 17'(atan_entry(4'(i)));
            end
         end
         c_ff <= c_in;
         s_ff <= s_in;
         r_ff[CordicIters+1] <= r_ff[CordicIters];
         mx_ff <= $signed({1'b0, r_ff[CordicIters+1].range}) * c_ff;
         my_ff <= $signed({1'b0, r_ff[CordicIters+1].range}) * s_ff;
         r_ff[CordicIters+2] <= r_ff[CordicIters+1];
         tx_ff <= tx_in;
         ty_ff <= ty_in;
         r_ff[Stages] <= r_ff[CordicIters+2];
         if (v_ff[Stages]) begin
            out_ff[0]     <= r_ff[Stages].point;
            out_ff[24:1]  <= r_ff[Stages].point ? sat24(tx_ff) : 24'd0;
            out_ff[48:25] <= r_ff[Stages].point ? sat24(ty_ff) : 24'd0;
            out_ff[49]    <= r_ff[Stages].counted;
            out_ff[62:50] <= r_ff[Stages].count;
            out_ff[63]    <= r_ff[Stages].last;
         end
      end
   end
endmodule
`default_nettype wire

[src/scan_ray_projection_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// scan_ray_projection_top
// laser scan ray to world point projector
// ----------------------------------------------------------------------------
// One ray word is taken per cycle while the queue is not full; one result
// word leaves per ray, in order. A result word passes the step out of the
// queue, sixteen cordic stages, the quadrant turn, the multiply, the offset
// add and the output register. The front counts rays as they arrive and a
// four-word queue lets it keep taking while the back pipe is held; once it
// holds four words the input stalls until the output side accepts again. The
// user must write registers only while no ray is in flight (not enforced).
module scan_ray_projection_top import srp_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // range_mm
   input  wire logic [2:0]  req_tuser,   // range_kind, first_ray
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,   // point_x, point_y, valid_count
   output logic [1:0]       rsp_tuser,   // point_valid, ray_counted
   output logic             rsp_tlast,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [22:0] csr_wdata
);
   logic [15:0] start_ff, step_ff, rmin_ff, rmax_ff, olim_ff;
   logic [4:0]  stride_ff;
   logic [22:0] sx_ff, sy_ff;
   ray_type     fr, qr;
   logic        full, ne, take, pop, brdy;
   logic [63:0] bdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0; step_ff <= '0; rmin_ff <= '0; rmax_ff <= 16'hFFFF;
         olim_ff <= 16'hFFFF; stride_ff <= 5'd1; sx_ff <= '0; sy_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_START_ANGLE: start_ff  <= csr_wdata[15:0];
            REG_ANGLE_STEP:  step_ff   <= csr_wdata[15:0];
            REG_RANGE_MIN:   rmin_ff   <= csr_wdata[15:0];
            REG_RANGE_MAX:   rmax_ff   <= csr_wdata[15:0];
            REG_OBST_LIMIT:  olim_ff   <= csr_wdata[15:0];
            REG_STRIDE:      stride_ff <= csr_wdata[4:0];
            REG_SENSOR_X:    sx_ff     <= csr_wdata;
            REG_SENSOR_Y:    sy_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_tready = !full;
   assign take = req_tvalid && !full;
   assign pop  = ne && brdy;

   srp_front u_front (
      .clock(clock), .reset(reset), .take(take),
      .range_mm(req_tdata), .range_kind(req_tuser[1:0]),
      .first_ray(req_tuser[2]), .last_ray(req_tlast),
      .start_angle(start_ff), .angle_step(step_ff), .min_range(rmin_ff),
      .max_range(rmax_ff), .obstacle_limit(olim_ff), .stride(stride_ff),
      .ray(fr)
   );

   srp_fifo u_fifo (
      .clock(clock), .reset(reset), .push(take), .push_data(fr), .full(full),
      .pop(pop), .not_empty(ne), .pop_data(qr)
   );

   srp_back u_back (
      .clock(clock), .reset(reset), .in_valid(ne), .in_ray(qr), .in_ready(brdy),
      .base_x(sx_ff), .base_y(sy_ff), .out_valid(rsp_tvalid),
      .out_ready(rsp_tready), .out_data(bdata)
   );

   assign rsp_tdata = {3'd0, bdata[62:50], bdata[48:25], bdata[24:1]};
   assign rsp_tuser = {bdata[49], bdata[0]};
   assign rsp_tlast = bdata[63];
endmodule
`default_nettype wire

[test/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the scan ray projector: scans of random rays under
// changing register settings, each result word checked against a predictor
// ----------------------------------------------------------------------------
module tb;
   import srp_pkg::*;

   localparam logic [1:0] KIND_NAN  = 2'd2;
   localparam logic [1:0] KIND_ODD  = 2'd3;
   localparam int         CycleLimit = 400000;
   localparam int         Settle     = 30;

   typedef struct {
      bit               point;
      bit signed [23:0] x;
      bit signed [23:0] y;
      bit               counted;
      bit [12:0]        count;
      bit               done;
   } point_word_type;

   class ray_scoreboard;
      bit [15:0]        start_angle = '0;
      bit signed [15:0] angle_step  = '0;
      bit [15:0]        min_range   = '0;
      bit [15:0]        max_range   = 16'hFFFF;
      bit [15:0]        obst_limit  = 16'hFFFF;
      bit [4:0]         stride      = 5'd1;
      bit signed [22:0] base_x      = '0;
      bit signed [22:0] base_y      = '0;
      bit [15:0]        angle_acc   = '0;
      bit [3:0]         phase_acc   = '0;
      bit [12:0]        ray_total   = '0;
      point_word_type   pending[$];
      int               errors  = 0;
      int               checked = 0;
      int               points  = 0;

      function void write_reg(logic [2:0] idx, logic [22:0] val);
         case (idx)
            REG_START_ANGLE: start_angle = val[15:0];
            REG_ANGLE_STEP:  angle_step  = val[15:0];
            REG_RANGE_MIN:   min_range   = val[15:0];
            REG_RANGE_MAX:   max_range   = val[15:0];
            REG_OBST_LIMIT:  obst_limit  = val[15:0];
            REG_STRIDE:      stride      = val[4:0];
            REG_SENSOR_X:    base_x      = val;
            default:         base_y      = val;
         endcase
      endfunction

      function longint round_q15(longint v);
         longint r;
         r = (v + 16384) >>> 15;
         if (r > 32767) r = 32767;
         if (r < -32768) r = -32768;
         return r;
      endfunction

      function void sin_cos(bit [15:0] a, output longint c, output longint s);
         longint x, y, nx, cr, sr;
         int     z;
         int     tab[16];
         tab = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0};
         x = 652032874;
         y = 0;
         z = int'(a[13:0]);
         for (int i = 0; i < 16; i++) begin
            if (z >= 0) begin
               nx = x - (y >>> i);
               y  = y + (x >>> i);
               z  = z - tab[i];
            end else begin
               nx = x + (y >>> i);
               y  = y - (x >>> i);
               z  = z + tab[i];
            end
            x = nx;
         end
         cr = round_q15(x);
         sr = round_q15(y);
         case (a[15:14])
            2'd0: begin c = cr;  s = sr;  end
            2'd1: begin c = -sr; s = cr;  end
            2'd2: begin c = -cr; s = -sr; end
            default: begin c = sr; s = -cr; end
         endcase
         if (c > 32767) c = 32767;
         if (s > 32767) s = 32767;
      endfunction

      function bit signed [23:0] project(longint base, bit [15:0] r, longint t);
         longint v;
         v = base + ((longint'(r) * t + 16384) >>> 15);
         if (v > 8388607) v = 8388607;
         if (v < -8388608) v = -8388608;
         return v[23:0];
      endfunction

      function void note_ray(bit [15:0] r, bit [1:0] kind, bit first, bit last);
         point_word_type w;
         bit [15:0]      ang;
         int             phase, eff;
         bit             hit;
         longint         c, s;
         eff = (stride == 0) ? 1 : (stride > 16 ? 16 : int'(stride));
         w = '{default: 0};
         if (first) begin
            ang = start_angle;
            phase = 0;
            ray_total = '0;
         end else begin
            ang = angle_acc;
            phase = int'(phase_acc);
         end
         if (phase == 0) begin
            hit = kind == KIND_FINITE && r >= min_range && r <= max_range;
            // clear rays only count when infinity is taken as valid
            w.counted = hit || (InfIsValid &&
                        (kind == KIND_POSINF || (kind == KIND_FINITE && r > max_range)));
            if (w.counted && ray_total < CountCap) ray_total++;
            if (hit && r <= obst_limit) begin
               sin_cos(ang, c, s);
               w.x = project(base_x, r, c);
               w.y = project(base_y, r, s);
               w.point = 1;
            end
         end
         phase++;
         if (phase >= eff) phase = 0;
         phase_acc = phase[3:0];
         angle_acc = ang + angle_step;
         w.count = ray_total;
         w.done = last;
         pending.insert(pending.size(), w);
      endfunction

      function void check_word(logic [63:0] d, logic [1:0] u, logic tl);
         point_word_type w;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result word, expected none, actual %h", $time, d);
            errors++;
            return;
         end
         w = pending.pop_front();
         checked++;
         if (w.point) points++;
         if (u[0] !== w.point) begin
            $display("%0t: point_valid expected %0d actual %0d", $time, w.point, u[0]);
            errors++;
         end
         if (d[23:0] !== w.x) begin
            $display("%0t: point_x expected %0d actual %0d", $time, w.x, $signed(d[23:0]));
            errors++;
         end
         if (d[47:24] !== w.y) begin
            $display("%0t: point_y expected %0d actual %0d", $time, w.y, $signed(d[47:24]));
            errors++;
         end
         if (u[1] !== w.counted) begin
            $display("%0t: ray_counted expected %0d actual %0d", $time, w.counted, u[1]);
            errors++;
         end
         if (d[60:48] !== w.count) begin
            $display("%0t: valid_count expected %0d actual %0d", $time, w.count, d[60:48]);
            errors++;
         end
         if (tl !== w.done) begin
            $display("%0t: scan_done expected %0d actual %0d", $time, w.done, tl);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [15:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tready = 1'b0;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = REG_START_ANGLE;
   logic [22:0] csr_wdata = '0;
   wire         req_tready, rsp_tvalid, rsp_tlast;
   wire [63:0]  rsp_tdata;
   wire [1:0]   rsp_tuser;

   ray_scoreboard sb = new();
   bit  calm = 0;
   bit  stall_req = 0;
   int  cycles = 0;
   int  rays_sent = 0;

   scan_ray_projection_top i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("%0t: timeout", $time);
         $display("Mismatches found");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_word(rsp_tdata, rsp_tuser, rsp_tlast);
   end

   // receiver: random back-pressure, plus one long hold when asked
   initial begin
      wait (!reset);
      forever begin
         if (stall_req) begin
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
            stall_req = 0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   task automatic send_ray(bit [15:0] r, bit [1:0] kind, bit first, bit last);
      req_tvalid <= 1'b1;
      req_tdata  <= r;
      req_tuser  <= {first, kind};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      sb.note_ray(r, kind, first, last);
      rays_sent++;
      if (!calm && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (Settle) @(posedge clock);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [22:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.write_reg(idx, val);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_all(bit [15:0] sa, bit [15:0] st, bit [15:0] rmin, bit [15:0] rmax,
                          bit [15:0] ol, bit [4:0] sd, bit [22:0] sx, bit [22:0] sy);
      drain();
      write_csr(REG_START_ANGLE, 23'(sa));
      write_csr(REG_ANGLE_STEP, 23'(st));
      write_csr(REG_RANGE_MIN, 23'(rmin));
      write_csr(REG_RANGE_MAX, 23'(rmax));
      write_csr(REG_OBST_LIMIT, 23'(ol));
      write_csr(REG_STRIDE, 23'(sd));
      write_csr(REG_SENSOR_X, sx);
      write_csr(REG_SENSOR_Y, sy);
   endtask

   // ranges biased towards the register boundaries
   function automatic bit [15:0] pick_range();
      case ($urandom_range(0, 7))
         0: return 16'(sb.min_range + $urandom_range(0, 2) - 1);
         1: return 16'(sb.max_range + $urandom_range(0, 2) - 1);
         2: return 16'(sb.obst_limit + $urandom_range(0, 2) - 1);
         3: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic random_scan();
      int  n;
      bit [1:0] kind;
      n = $urandom_range(1, 40);
      for (int i = 0; i < n; i++) begin
         kind = ($urandom_range(0, 4) == 0) ? 2'($urandom_range(1, 3)) : KIND_FINITE;
         if ($urandom_range(0, 19) == 0)
            send_ray(16'($urandom), 2'($urandom), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
         else
            send_ray(pick_range(), kind, i == 0, i == n - 1);
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // defaults, scan started without a first ray
      send_ray(16'd1000, KIND_FINITE, 0, 0);
      send_ray(16'd0, KIND_FINITE, 0, 0);
      send_ray(16'hFFFF, KIND_FINITE, 0, 0);
      send_ray(16'd500, KIND_POSINF, 0, 0);
      send_ray(16'd500, KIND_NAN, 0, 0);
      send_ray(16'd500, KIND_ODD, 0, 1);

      // extremes of angle, step, sensor and stride
      set_all(16'hFFFF, 16'h7FFF, 16'd100, 16'd60000, 16'd30000, 5'd3,
              23'h3FFFFF, 23'h400000);
      send_ray(16'd60000, KIND_FINITE, 1, 0);
      send_ray(16'd20000, KIND_FINITE, 0, 0);
      send_ray(16'd20000, KIND_FINITE, 0, 0);
      send_ray(16'd20000, KIND_FINITE, 0, 0);
      send_ray(16'd99, KIND_FINITE, 0, 0);
      send_ray(16'd60001, KIND_FINITE, 0, 0);
      send_ray(16'd30000, KIND_FINITE, 0, 0);
      send_ray(16'd30001, KIND_FINITE, 0, 1);
      set_all(16'h4000, 16'h8000, 16'd0, 16'hFFFF, 16'hFFFF, 5'd16,
              23'h400000, 23'h3FFFFF);
      for (int i = 0; i < 20; i++) send_ray(16'hFFFF, KIND_FINITE, i == 0, i == 19);
      // stride zero and min above max
      set_all(16'h8000, 16'd1, 16'd5000, 16'd1000, 16'd3000, 5'd0, 23'd0, 23'd0);
      for (int i = 0; i < 6; i++) send_ray(16'(2000 + i), KIND_FINITE, i == 0, i == 5);
      drain();
      write_csr(REG_STRIDE, 23'd31);
      for (int i = 0; i < 20; i++) send_ray(16'd2000, KIND_FINITE, i == 0, i == 19);

      // random settings, each with a run of scans
      for (int p = 0; p < 8; p++) begin
         set_all(16'($urandom), 16'($urandom), 16'($urandom_range(0, 3000)),
                 16'($urandom_range(20000, 65535)), 16'($urandom_range(10000, 65535)),
                 5'($urandom_range(0, 31)), 23'($urandom), 23'($urandom));
         if (p == 3) begin
            stall_req = 1;
            for (int i = 0; i < 40; i++) send_ray(pick_range(), KIND_FINITE, i == 0, i == 39);
         end
         while (rays_sent < 60 * (p + 1) + 60) random_scan();
      end

      // one long scan of hits back to back, no idling
      set_all(16'd0, 16'd16, 16'd0, 16'hFFFF, 16'hFFFF, 5'd1, 23'd1000, 23'h7FFC18);
      calm = 1;
      for (int i = 0; i < 100; i++) send_ray(16'd12345, KIND_FINITE, i == 0, i == 99);
      drain();

      $display("rays sent %0d, result words checked %0d, points %0d", rays_sent,
               sb.checked, sb.points);
      $display("covered register extremes, stride skipping, odd kinds and long stalls");
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("%0t: %0d expected words left over", $time, sb.pending.size());
         $display("Mismatches found");
      end
      $finish;
   end
endmodule

[filelist.f]
src/srp_pkg.sv
src/srp_front.sv
src/srp_fifo.sv
src/srp_back.sv
src/scan_ray_projection_top.sv
test/tb.sv
